>>> sv/sate_pkg.sv
`timescale 1ns / 1ps
package sate_pkg;
  localparam int CAPACITY_DEFAULT  = 256;
  localparam int ITEM_BITS_DEFAULT = 32;
  localparam int KIND_W  = 3;
  localparam int POS_W   = 9;
  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6,
    OP_NONE          = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_INS_RD,
    ST_INS_WR,
    ST_CMP_RD,
    ST_CMP_WR,
    ST_GET_RD,
    ST_GET_WAIT,
    ST_DONE
  } state_t;
endpackage

>>> sv/sorted_array_table_engine_top.sv
`timescale 1ns / 1ps
// Ordered table of up to CAPACITY words held in one synchronous RAM, plus an
// entry count.
// Request channel (valid/ready): kind, position, item_value. Result channel
// (valid/ready): status, index, read_data, removed, entry_count; exactly one
// result per request.
// One request at a time. Cost is set by the single RAM port pair; each entry
// is read in one state and then written or checked in the next state:
//   get: RAM read, then wait; set: written at once; failures: straight to result
//   find / insert_sorted search: read, then check, per entry scanned
//   insert: read, then write, per entry shifted up, from the top down
//   erase_at / remove_all: read, then write, per entry visited (compacting pass)
// The result is held in an output register until taken; a new request is
// taken once that result has been accepted.
// Reset clears the count and the control state; RAM contents are undefined
// and are never read beyond the count, so no clearing pass is needed.
module sorted_array_table_engine_top #(
  parameter int CAPACITY  = sate_pkg::CAPACITY_DEFAULT,
  parameter int ITEM_BITS = sate_pkg::ITEM_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [8:0]  position,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [8:0]  index,
  output logic [31:0] read_data,
  output logic [8:0]  removed,
  output logic [8:0]  entry_count
);
  import sate_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int IW = (ITEM_BITS < VALUE_W) ? ITEM_BITS : VALUE_W;

  logic [ITEM_BITS-1:0] mem [CAPACITY];
  logic [ITEM_BITS-1:0] rd_q;

  state_t state, state_next;
  op_t op;
  logic [CW-1:0] cnt, ptr, wptr, pos, rem;
  logic [ITEM_BITS-1:0] val;

  // RAM port control
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [ITEM_BITS-1:0] wdata;
  logic          re;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // compare the request position at full width so no high bits are lost
  logic [PW-1:0] pos_in, cnt_w;
  logic          rd_match, rd_ge, set_ok;
  assign pos_in   = PW'(position);
  assign cnt_w    = PW'(cnt);
  assign rd_match = (rd_q == val);
  assign rd_ge    = (val <= rd_q);
  assign set_ok   = (op_t'(kind) == OP_SET) && (pos_in < cnt_w);

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        unique case (op_t'(kind))
          OP_INSERT_AT:     state_next = (cnt < CW'(CAPACITY) && pos_in <= cnt_w) ?
                                         ST_INS_RD : ST_DONE;
          OP_INSERT_SORTED: state_next = (cnt < CW'(CAPACITY)) ? ST_SCAN_RD : ST_DONE;
          OP_FIND:          state_next = ST_SCAN_RD;
          OP_ERASE_AT:      state_next = (pos_in < cnt_w) ? ST_CMP_RD : ST_DONE;
          OP_REMOVE_ALL:    state_next = ST_CMP_RD;
          OP_GET:           state_next = (pos_in < cnt_w) ? ST_GET_RD : ST_DONE;
          default:          state_next = ST_DONE;
        endcase
      end
      ST_SCAN_RD:  state_next = (ptr < cnt) ? ST_SCAN_CHK : ((op == OP_FIND) ? ST_DONE : ST_INS_RD);
      ST_SCAN_CHK: begin
        if (op == OP_FIND) state_next = rd_match ? ST_DONE : ST_SCAN_RD;
        else               state_next = rd_ge ? ST_INS_RD : ST_SCAN_RD;
      end
      ST_INS_RD:   state_next = ST_INS_WR;
      ST_INS_WR:   state_next = (wptr > pos) ? ST_INS_RD : ST_DONE;
      ST_CMP_RD:   state_next = (ptr < cnt) ? ST_CMP_WR : ST_DONE;
      ST_CMP_WR:   state_next = ST_CMP_RD;
      ST_GET_RD:   state_next = ST_GET_WAIT;
      ST_GET_WAIT: state_next = ST_DONE;
      ST_DONE:     state_next = out_ready ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // RAM access per state
  always_comb begin
    we = 1'b0; waddr = '0; wdata = val; re = 1'b0; raddr = '0;
    unique case (state)
      ST_SCAN_RD: begin re = (ptr < cnt); raddr = AW'(ptr); end
      ST_INS_RD: begin
        re = (wptr > pos); raddr = AW'(wptr - CW'(1));
      end
      ST_INS_WR: begin
        we = 1'b1; waddr = AW'(wptr);
        wdata = (wptr > pos) ? rd_q : val;
      end
      ST_CMP_RD: begin re = (ptr < cnt); raddr = AW'(ptr); end
      ST_CMP_WR: begin we = 1'b1; waddr = AW'(wptr); wdata = rd_q; end
      ST_GET_RD: begin re = 1'b1; raddr = AW'(pos); end
      ST_IDLE: if (in_valid && set_ok) begin
        we = 1'b1; waddr = AW'(pos_in); wdata = ITEM_BITS'(item_value);
      end
      default: ;
    endcase
  end

  logic drop;
  always_comb begin
    if (op == OP_ERASE_AT) drop = (ptr == pos);
    else                   drop = rd_match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cnt <= '0; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          op   <= op_t'(kind);
          pos  <= CW'(pos_in);
          val  <= ITEM_BITS'(item_value);
          ptr  <= '0;
          wptr <= (op_t'(kind) == OP_ERASE_AT || op_t'(kind) == OP_REMOVE_ALL) ?
                  '0 : cnt;
          rem  <= '0;
          status <= !set_ok; index <= set_ok ? position : '0;
          read_data <= '0; removed <= '0;
          if (state_next == ST_DONE) begin
            out_valid <= 1'b1; entry_count <= 9'(cnt);
          end
        end
        ST_SCAN_RD: if (!(ptr < cnt)) begin
          if (op == OP_FIND) begin
            out_valid <= 1'b1; entry_count <= 9'(cnt);
          end else pos <= ptr;
        end
        ST_SCAN_CHK: begin
          if (op == OP_FIND && rd_match) begin
            status <= 1'b0; index <= 9'(ptr);
            out_valid <= 1'b1; entry_count <= 9'(cnt);
          end else if (op == OP_INSERT_SORTED && rd_ge) pos <= ptr;
          ptr <= ptr + CW'(1);
        end
        ST_INS_WR: begin
          if (wptr > pos) wptr <= wptr - CW'(1);
          else begin
            cnt <= cnt + CW'(1);
            status <= 1'b0; index <= 9'(pos);
            out_valid <= 1'b1; entry_count <= 9'(cnt + CW'(1));
          end
        end
        ST_CMP_RD: if (!(ptr < cnt)) begin
          cnt <= wptr;
          status <= 1'b0; out_valid <= 1'b1; entry_count <= 9'(wptr);
          if (op == OP_ERASE_AT) index <= 9'(pos);
          else removed <= 9'(rem);
        end
        ST_CMP_WR: begin
          // skip the dropped entry (value match, or the erase position), else keep it at the write pointer
          if (drop) rem <= rem + CW'(1);
          else      wptr <= wptr + CW'(1);
          ptr <= ptr + CW'(1);
        end
        ST_GET_WAIT: begin
          status <= 1'b0; index <= 9'(pos);
          read_data <= VALUE_W'(rd_q[IW-1:0]);
          out_valid <= 1'b1; entry_count <= 9'(cnt);
        end
        ST_DONE: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // the write in ST_CMP_WR may overwrite a kept slot only at or below the read pointer
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP_WR |-> wptr <= ptr) else $error("compaction overtook read");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY)) else $error("count overflow");
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_DONE) else $error("result outside done");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("accept while result pending");
endmodule
